>>> sv/fen_pp_pkg.sv
// ----------------------------------------------------------------------------
// fen_pp_pkg
// Shared types and constants for the FEN position parser.
// ----------------------------------------------------------------------------
package fen_pp_pkg;

  typedef enum logic [3:0] {
    PH_PLACE,
    PH_SEP_A,
    PH_SIDE,
    PH_SEP_B,
    PH_CASTLE,
    PH_EP_FILE,
    PH_EP_RANK,
    PH_SEP_C,
    PH_HALF_FIRST,
    PH_HALF_SECOND,
    PH_HALF_EXTRA,
    PH_DONE
  } phase_t;

  // map indexes
  localparam int unsigned M_PAWN   = 0;
  localparam int unsigned M_KNIGHT = 1;
  localparam int unsigned M_BISHOP = 2;
  localparam int unsigned M_ROOK   = 3;
  localparam int unsigned M_QUEEN  = 4;
  localparam int unsigned M_KING   = 5;
  localparam int unsigned M_WHITE  = 6;
  localparam int unsigned M_BLACK  = 7;
  localparam int unsigned N_MAPS   = 8;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_K     = 8'h6B;
  localparam logic [7:0] CH_UK    = 8'h4B;
  localparam logic [7:0] CH_UQ    = 8'h51;
  localparam logic [7:0] CH_CASE  = 8'h20;

  localparam logic [6:0] NO_EP    = 7'd64;

  // castling bits
  localparam logic [3:0] CR_WK = 4'd1;
  localparam logic [3:0] CR_WQ = 4'd2;
  localparam logic [3:0] CR_BK = 4'd4;
  localparam logic [3:0] CR_BQ = 4'd8;

  // placement step result
  typedef struct packed {
    logic [2:0]        rank;     // cursor after the byte
    logic [2:0]        file;
    logic              leave;    // rank 1 complete
    logic              to_side;  // early space
    logic [N_MAPS-1:0] map_sel;  // maps that take the square
    logic [5:0]        sq;       // square of the byte
  } place_upd_t;

endpackage

>>> sv/fen_pp_place.sv
// ----------------------------------------------------------------------------
// fen_pp_place
// Board placement step: decodes one byte against the rank/file cursor.
// ----------------------------------------------------------------------------
module fen_pp_place (
  input  logic [7:0]             char_byte,
  input  logic [2:0]             rank,
  input  logic [2:0]             file,
  output fen_pp_pkg::place_upd_t upd
);
  import fen_pp_pkg::*;

  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic [4:0] digit_sum;
  logic [7:0] lc;
  logic       wrap;

  assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_upper  = (char_byte >= CH_UA) && (char_byte <= CH_UZ);
  assign is_lower  = (char_byte >= CH_LA) && (char_byte <= CH_LZ);
  assign digit_sum = {2'b00, file} + {1'b0, char_byte[3:0]};
  assign lc        = char_byte | CH_CASE;

  always_comb begin
    upd         = '0;
    upd.rank    = rank;
    upd.file    = file;
    upd.sq      = {rank, file};
    wrap        = 1'b0;
    if (is_digit) begin
      if (digit_sum >= 5'd8) begin
        wrap = 1'b1;
      end else begin
        upd.file = digit_sum[2:0];
      end
    end else if (char_byte == CH_SLASH) begin
      upd.file = '0;
    end else if (char_byte == CH_SPACE) begin
      upd.to_side = 1'b1;
    end else if (is_upper || is_lower) begin
      upd.map_sel[is_upper ? M_WHITE : M_BLACK] = 1'b1;
      case (lc)
        CH_P:    upd.map_sel[M_PAWN]   = 1'b1;
        CH_N:    upd.map_sel[M_KNIGHT] = 1'b1;
        CH_B:    upd.map_sel[M_BISHOP] = 1'b1;
        CH_R:    upd.map_sel[M_ROOK]   = 1'b1;
        CH_Q:    upd.map_sel[M_QUEEN]  = 1'b1;
        CH_K:    upd.map_sel[M_KING]   = 1'b1;
        default: ;
      endcase
      if (file == 3'd7) begin
        wrap = 1'b1;
      end else begin
        upd.file = file + 3'd1;
      end
    end
    if (wrap) begin
      upd.file = '0;
      if (rank == '0) begin
        upd.leave = 1'b1;
      end else begin
        upd.rank = rank - 3'd1;
      end
    end
  end

endmodule

>>> sv/fen_position_parser_unit.sv
// ----------------------------------------------------------------------------
// fen_position_parser_unit
// FEN record parser: one byte per transfer in, one full position out.
// ----------------------------------------------------------------------------
// Latency: a result appears on out_* the cycle after the byte that ends the
//   halfmove field is transferred (one register stage).
// Throughput: one byte per cycle; the input stalls only while a finished
//   result sits in the output register and out_tready is low.
// Reset (rst_n low, synchronous): maps cleared, cursor at rank 8 file a,
//   placement phase, flags cleared, en-passant none, output register empty.
// ----------------------------------------------------------------------------
module fen_position_parser_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_byte
  input  logic         in_tuser,   // [0] new_record
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] pawn_map, [127:64] knight_map, [191:128] bishop_map,
  // [255:192] rook_map, [319:256] queen_map, [383:320] king_map,
  // [447:384] white_map, [511:448] black_map, [512] black_to_move,
  // [516:513] castle_rights, [523:517] ep_square, [530:524] halfmove_count,
  // [535:531] zero
  output logic [535:0] out_tdata
);
  import fen_pp_pkg::*;

  // parser state
  logic [N_MAPS-1:0][63:0] maps_r, maps_nxt, maps_cur;
  logic [2:0]              rank_r, rank_nxt, rank_cur;
  logic [2:0]              file_r, file_nxt, file_cur;
  phase_t                  phase_r, phase_nxt, phase_cur;
  logic                    side_r, side_nxt, side_cur;
  logic [3:0]              castle_r, castle_nxt, castle_cur;
  logic [2:0]              epf_r, epf_nxt, epf_cur;
  logic [6:0]              ep_r, ep_nxt, ep_cur;
  logic [6:0]              half_r, half_nxt, half_cur;

  // output register
  logic                    out_valid_r;
  logic [535:0]            out_data_r, out_data_nxt;

  logic                    in_xfer;
  logic                    emit;
  logic [7:0]              c;
  logic                    c_digit;
  logic [63:0]             sq_bit;
  place_upd_t              pu;

  assign c       = in_tdata;
  assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  // accept unless a result is waiting and will not move this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // new_record clears everything before the byte is used
  always_comb begin
    if (in_tuser) begin
      maps_cur   = '0;
      rank_cur   = 3'd7;
      file_cur   = '0;
      phase_cur  = PH_PLACE;
      side_cur   = 1'b0;
      castle_cur = '0;
      epf_cur    = '0;
      ep_cur     = NO_EP;
      half_cur   = '0;
    end else begin
      maps_cur   = maps_r;
      rank_cur   = rank_r;
      file_cur   = file_r;
      phase_cur  = phase_r;
      side_cur   = side_r;
      castle_cur = castle_r;
      epf_cur    = epf_r;
      ep_cur     = ep_r;
      half_cur   = half_r;
    end
  end

  fen_pp_place u_place (
    .char_byte (c),
    .rank      (rank_cur),
    .file      (file_cur),
    .upd       (pu)
  );

  assign sq_bit = 64'd1 << pu.sq;

  always_comb begin
    maps_nxt   = maps_cur;
    rank_nxt   = rank_cur;
    file_nxt   = file_cur;
    phase_nxt  = phase_cur;
    side_nxt   = side_cur;
    castle_nxt = castle_cur;
    epf_nxt    = epf_cur;
    ep_nxt     = ep_cur;
    half_nxt   = half_cur;
    emit       = 1'b0;
    unique case (phase_cur)
      PH_PLACE: begin
        for (int i = 0; i < N_MAPS; i++) begin
          if (pu.map_sel[i]) begin
            maps_nxt[i] = maps_cur[i] | sq_bit;
          end
        end
        rank_nxt = pu.rank;
        file_nxt = pu.file;
        if (pu.to_side) begin
          phase_nxt = PH_SIDE;
        end else if (pu.leave) begin
          phase_nxt = PH_SEP_A;
        end
      end
      PH_SEP_A: phase_nxt = PH_SIDE;
      PH_SIDE: begin
        side_nxt  = (c == CH_B);
        phase_nxt = PH_SEP_B;
      end
      PH_SEP_B: phase_nxt = PH_CASTLE;
      PH_CASTLE: begin
        case (c)
          CH_UK:    castle_nxt = castle_cur | CR_WK;
          CH_UQ:    castle_nxt = castle_cur | CR_WQ;
          CH_K:     castle_nxt = castle_cur | CR_BK;
          CH_Q:     castle_nxt = castle_cur | CR_BQ;
          CH_SPACE: phase_nxt  = PH_EP_FILE;
          default:  ;
        endcase
      end
      PH_EP_FILE: begin
        if (c == CH_DASH) begin
          ep_nxt    = NO_EP;
          phase_nxt = PH_SEP_C;
        end else begin
          // (c - 'a') & 7; 'a' has low bits 001
          epf_nxt   = c[2:0] - 3'd1;
          phase_nxt = PH_EP_RANK;
        end
      end
      PH_EP_RANK: begin
        // ((c - '1') & 7) * 8 + file; '1' has low bits 001
        ep_nxt    = {1'b0, c[2:0] - 3'd1, epf_cur};
        phase_nxt = PH_SEP_C;
      end
      PH_SEP_C: phase_nxt = PH_HALF_FIRST;
      PH_HALF_FIRST: begin
        if (c_digit) begin
          half_nxt  = {3'b000, c[3:0]};
          phase_nxt = PH_HALF_SECOND;
        end else begin
          half_nxt  = '0;
          phase_nxt = PH_DONE;
          emit      = 1'b1;
        end
      end
      PH_HALF_SECOND: begin
        if (c_digit) begin
          // hold * 10 + digit, at most 99
          half_nxt  = (half_cur << 3) + (half_cur << 1) + {3'b000, c[3:0]};
          phase_nxt = PH_HALF_EXTRA;
        end else begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
        end
      end
      PH_HALF_EXTRA: begin
        if (!c_digit) begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
        end
      end
      default: phase_nxt = PH_DONE;
    endcase
  end

  assign out_data_nxt = {5'b00000, half_nxt, ep_nxt, castle_nxt, side_nxt,
                         maps_nxt[M_BLACK], maps_nxt[M_WHITE],
                         maps_nxt[M_KING],  maps_nxt[M_QUEEN],
                         maps_nxt[M_ROOK],  maps_nxt[M_BISHOP],
                         maps_nxt[M_KNIGHT], maps_nxt[M_PAWN]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maps_r   <= '0;
      rank_r   <= 3'd7;
      file_r   <= '0;
      phase_r  <= PH_PLACE;
      side_r   <= 1'b0;
      castle_r <= '0;
      epf_r    <= '0;
      ep_r     <= NO_EP;
      half_r   <= '0;
    end else if (in_xfer) begin
      maps_r   <= maps_nxt;
      rank_r   <= rank_nxt;
      file_r   <= file_nxt;
      phase_r  <= phase_nxt;
      side_r   <= side_nxt;
      castle_r <= castle_nxt;
      epf_r    <= epf_nxt;
      ep_r     <= ep_nxt;
      half_r   <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a pending result must hold off further input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while result pending");

  // a result always leaves the parser in the done phase
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && emit |=> phase_r == PH_DONE && out_valid_r)
    else $error("result emitted without done phase");

  // castling bits move only inside the castling field or on a new record
  a_castle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_tuser && phase_r != PH_CASTLE |=> $stable(castle_r))
    else $error("castling flags changed outside castling field");

  // halfmove count never exceeds two decimal digits
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    half_r <= 7'd99)
    else $error("halfmove count out of range");

endmodule

>>> tb/sv/fen_position_checker.sv
// ----------------------------------------------------------------------------
// fen_position_checker
// Watches both streams of the FEN parser, keeps its own parse of the byte
// stream and compares every position transfer field by field.
// ----------------------------------------------------------------------------
module fen_position_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [535:0] out_tdata,
  output int unsigned  mismatches,
  output int unsigned  outstanding,
  output int unsigned  positions_seen
);
  import fen_pp_pkg::*;

  localparam logic [7:0] CH_ONE = 8'h31;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [4:0]       pad;
    logic [6:0]       halfmove;
    logic [6:0]       ep_sq;
    logic [3:0]       castle;
    logic             black_move;
    logic [7:0][63:0] maps;
  } position_t;

  string map_label [8] = '{"pawn_map", "knight_map", "bishop_map", "rook_map",
                           "queen_map", "king_map", "white_map", "black_map"};

  position_t        position_q [$];
  position_t        want;
  position_t        got;

  // parser state
  logic [7:0][63:0] maps;
  int unsigned      rank;
  int unsigned      file;
  phase_t           phase;
  logic             black_move;
  logic [3:0]       castle;
  logic [2:0]       ep_file;
  logic [6:0]       ep_sq;
  logic [6:0]       halfmove;

  task automatic clear_position();
    maps       = '0;
    rank       = 7;
    file       = 0;
    phase      = PH_PLACE;
    black_move = 1'b0;
    castle     = '0;
    ep_file    = '0;
    ep_sq      = NO_EP;
    halfmove   = '0;
  endtask

  // rank 1 complete means placement is over
  task automatic next_rank();
    file = 0;
    if (rank == 0) begin
      phase = PH_SEP_A;
    end else begin
      rank--;
    end
  endtask

  task automatic close_position();
    position_t p;
    p.pad        = '0;
    p.halfmove   = halfmove;
    p.ep_sq      = ep_sq;
    p.castle     = castle;
    p.black_move = black_move;
    p.maps       = maps;
    position_q.push_back(p);
    phase = PH_DONE;
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic fresh);
    logic       digit;
    logic       upper;
    logic       lower;
    logic [5:0] sq;
    logic [7:0] lc;
    logic [7:0] dv;
    logic [7:0] delta;
    if (fresh) clear_position();
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    upper = (c >= CH_UA) && (c <= CH_UZ);
    lower = (c >= CH_LA) && (c <= CH_LZ);
    dv    = c - CH_ZERO;
    case (phase)
      PH_PLACE: begin
        if (digit) begin
          file += dv;
          if (file >= 8) next_rank();
        end else if (c == CH_SLASH) begin
          file = 0;
        end else if (c == CH_SPACE) begin
          phase = PH_SIDE;
        end else if (upper || lower) begin
          sq = 6'(rank * 8 + file);
          maps[upper ? M_WHITE : M_BLACK][sq] = 1'b1;
          lc = upper ? c + CH_CASE : c;
          case (lc)
            CH_P:    maps[M_PAWN][sq]   = 1'b1;
            CH_N:    maps[M_KNIGHT][sq] = 1'b1;
            CH_B:    maps[M_BISHOP][sq] = 1'b1;
            CH_R:    maps[M_ROOK][sq]   = 1'b1;
            CH_Q:    maps[M_QUEEN][sq]  = 1'b1;
            CH_K:    maps[M_KING][sq]   = 1'b1;
            default: ;
          endcase
          file++;
          if (file >= 8) next_rank();
        end
      end
      PH_SEP_A: phase = PH_SIDE;
      PH_SIDE: begin
        black_move = (c == CH_B);
        phase      = PH_SEP_B;
      end
      PH_SEP_B: phase = PH_CASTLE;
      PH_CASTLE: begin
        if (c == CH_UK)         castle |= CR_WK;
        else if (c == CH_UQ)    castle |= CR_WQ;
        else if (c == CH_K)     castle |= CR_BK;
        else if (c == CH_Q)     castle |= CR_BQ;
        else if (c == CH_SPACE) phase = PH_EP_FILE;
      end
      PH_EP_FILE: begin
        if (c == CH_DASH) begin
          ep_sq = NO_EP;
          phase = PH_SEP_C;
        end else begin
          delta   = c - CH_LA;
          ep_file = delta[2:0];
          phase   = PH_EP_RANK;
        end
      end
      PH_EP_RANK: begin
        delta = c - CH_ONE;
        ep_sq = {1'b0, delta[2:0], ep_file};
        phase = PH_SEP_C;
      end
      PH_SEP_C: phase = PH_HALF_FIRST;
      PH_HALF_FIRST: begin
        if (digit) begin
          halfmove = dv[6:0];
          phase    = PH_HALF_SECOND;
        end else begin
          halfmove = '0;
          close_position();
        end
      end
      PH_HALF_SECOND: begin
        if (digit) begin
          halfmove = halfmove * 7'd10 + dv[6:0];
          phase    = PH_HALF_EXTRA;
        end else begin
          close_position();
        end
      end
      PH_HALF_EXTRA: if (!digit) close_position();
      default: phase = PH_DONE;
    endcase
  endtask

  task automatic check_field(input string what, input logic [63:0] w, input logic [63:0] g);
    if (g !== w) begin
      mismatches++;
      if (mismatches <= 10)
        $display("position %0d: %s expected %h, got %h", positions_seen, what, w, g);
    end
  endtask

  // output side first: a result never leaves in the cycle its last byte arrives
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_position();
      position_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        positions_seen++;
        if (position_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("position %0d arrived with none expected", positions_seen);
        end else begin
          want = position_q.pop_front();
          for (int m = 0; m < N_MAPS; m++)
            check_field(map_label[m], want.maps[m], got.maps[m]);
          check_field("black_to_move", 64'(want.black_move), 64'(got.black_move));
          check_field("castle_rights", 64'(want.castle), 64'(got.castle));
          check_field("ep_square", 64'(want.ep_sq), 64'(got.ep_sq));
          check_field("halfmove_count", 64'(want.halfmove), 64'(got.halfmove));
          check_field("padding", 64'(want.pad), 64'(got.pad));
        end
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tuser);
    end
    outstanding = position_q.size();
  end

endmodule

>>> tb/sv/fen_position_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// fen_position_parser_unit_tb
// Feeds FEN records byte by byte into the parser: a few hand-built records for
// the corner cases, then random well-formed, damaged and junk records under
// several idle and stall patterns. Checking sits in fen_position_checker.
// ----------------------------------------------------------------------------
module fen_position_parser_unit_tb;
  import fen_pp_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1550;
  localparam int unsigned SQUEEZE_CYCLES = 300;    // long output hold-off
  localparam int unsigned CYCLE_LIMIT    = 400000;

  localparam logic [7:0] CH_W   = 8'h77;
  localparam logic [7:0] CH_ONE = 8'h31;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;   // [7:0] char_byte
  logic         in_tuser   = 1'b0; // [0] new_record
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [535:0] out_tdata;         // maps, side, castling, ep square, halfmove

  int unsigned  mismatches;
  int unsigned  outstanding;
  int unsigned  positions_seen;

  // idle pattern per phase: none, sender, receiver, both lightly
  int unsigned  tx_idle_by_phase [4] = '{0, 77, 0, 6};
  int unsigned  rx_stall_by_phase [4] = '{0, 0, 77, 6};
  int unsigned  tx_idle_pct  = 0;
  int unsigned  rx_stall_pct = 0;

  logic         hold_off    = 1'b0;
  logic         squeeze_req = 1'b0;

  // pending bytes: {counted, new_record, char}
  logic [9:0]   byte_q [$];
  bit           fresh_next    = 1'b0;
  int unsigned  items_sent    = 0;
  int unsigned  records_built = 0;
  int unsigned  clean_records = 0;
  int unsigned  cycle_count   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fen_position_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fen_position_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .positions_seen (positions_seen)
  );

  // Receiver: random back-pressure, or held off completely during the squeeze.
  always @(negedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Squeeze: once requested, refuse results for a long stretch so the output
  // register fills and the parser has to stall its input.
  initial begin
    wait (squeeze_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles, %0d positions still due", cycle_count, outstanding);
    $display("[fen_position_parser_unit] ERROR");
    $finish;
  end

  // Queue one byte; the first byte after fresh_next is set carries new_record.
  task automatic put(input logic [7:0] c, input bit counted = 1'b1);
    byte_q.push_back({counted, fresh_next, c});
    fresh_next = 1'b0;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // Empty squares as a digit; now and then split into two digits.
  task automatic flush_empties(inout int unsigned n);
    int unsigned k;
    if (n > 1 && $urandom_range(7) == 0) begin
      k = $urandom_range(1, n - 1);
      put(8'(CH_ZERO + k));
      put(8'(CH_ZERO + n - k));
    end else if (n > 0) begin
      put(8'(CH_ZERO + n));
    end
    n = 0;
  endtask

  // One FEN record with random content. When damaged, one byte is replaced
  // by junk (maybe a stray new_record) or the record is cut short.
  task automatic build_record(input bit damage);
    int unsigned first;
    int unsigned density;
    int unsigned empties;
    int unsigned stop_rank;
    int unsigned rot;
    int unsigned hm;
    int unsigned idx;
    logic [3:0]  mask;
    logic [7:0]  c;
    string       pieces;
    string       rights;
    pieces     = "PNBRQKpnbrqk";
    rights     = "KQkq";
    first      = byte_q.size();
    fresh_next = 1'b1;
    density    = $urandom_range(100);
    // occasionally end placement early with a space
    stop_rank  = ($urandom_range(9) == 0) ? $urandom_range(7) : 8;
    for (int r = 0; r < 8; r++) begin
      if (r == stop_rank) break;
      empties = 0;
      for (int f = 0; f < 8; f++) begin
        if ($urandom_range(99) < density) begin
          flush_empties(empties);
          put(pieces[$urandom_range(11)]);
        end else begin
          empties++;
        end
      end
      flush_empties(empties);
      if (r < 7 && r + 1 != stop_rank) put(CH_SLASH);
    end
    put(CH_SPACE);
    put($urandom_range(1) ? CH_B : CH_W);
    put(CH_SPACE);
    mask = 4'($urandom_range(15));
    if (mask == 0 || $urandom_range(4) == 0) begin
      put(CH_DASH);
    end else begin
      rot = $urandom_range(3);
      for (int i = 0; i < 4; i++)
        if (mask[(rot + i) % 4]) put(rights[(rot + i) % 4]);
    end
    put(CH_SPACE);
    if ($urandom_range(2) == 0) begin
      put(CH_DASH);
    end else begin
      put(8'(CH_LA + $urandom_range(7)));
      put(8'(CH_ONE + $urandom_range(7)));
    end
    put(CH_SPACE);
    case ($urandom_range(7))
      0:       hm = 0;
      1:       hm = 99;
      default: hm = $urandom_range(99);
    endcase
    if (hm >= 10 || $urandom_range(3) == 0) put(8'(CH_ZERO + hm / 10));
    put(8'(CH_ZERO + hm % 10));
    if (hm >= 10 && $urandom_range(7) == 0) put(8'(CH_ZERO + $urandom_range(9)));
    // terminator: normally a space, sometimes any other non-digit
    if ($urandom_range(7) == 0) begin
      do c = 8'($urandom_range(255)); while (c >= CH_ZERO && c <= CH_NINE);
      put(c);
    end else begin
      put(CH_SPACE);
    end
    // fullmove number: ignored by the parser
    repeat ($urandom_range(1, 3)) put(8'(CH_ZERO + $urandom_range(9)), 1'b0);
    if (damage && byte_q.size() > first + 1) begin
      idx = $urandom_range(first + 1, byte_q.size() - 1);
      if ($urandom_range(1)) begin
        c = 8'($urandom_range(255));
        byte_q[idx] = {1'b1, ($urandom_range(7) == 0), c};
      end else begin
        while (byte_q.size() > idx) void'(byte_q.pop_back());
      end
    end else if (!damage) begin
      clean_records++;
    end
    records_built++;
  endtask

  task automatic build_junk();
    repeat ($urandom_range(1, 24)) begin
      fresh_next = ($urandom_range(9) == 0);
      put(8'($urandom_range(255)));
    end
  endtask

  // One transfer. Idle cycles drop tvalid and put junk on tdata.
  task automatic send_item(input logic [7:0] c, input logic nr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= nr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_bytes();
    logic [9:0] e;
    while (byte_q.size() > 0) begin
      e = byte_q.pop_front();
      send_item(e[7:0], e[8]);
      if (e[9]) items_sent++;
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned roll;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed records.
    // Digits alone fill the board, so the byte after it is a skipped
    // separator; junk separators; no castling; ep h8; empty halfmove.
    // A byte after the result is ignored.
    fresh_next = 1'b1;
    put_text("88888888");
    put(8'hFF);
    put(CH_W);
    put(8'h00);
    put(CH_SPACE);
    put_text("h8");
    put(8'h80);
    put(CH_DASH);
    put(8'h7F, 1'b0);
    // Unknown letter, digit overrun, '/', '0', junk byte, early space,
    // black to move, all castling in odd order with '-', ep a1, count 99
    // with an extra digit, non-space terminator.
    fresh_next = 1'b1;
    put_text("kZ9/0!Pq b qkQK- a1 995x");
    drain_bytes();

    // Random records across the idle patterns; the squeeze runs early on,
    // while the sender offers bytes back to back.
    base = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_idle_by_phase[ph];
      rx_stall_pct = rx_stall_by_phase[ph];
      if (ph == 0) squeeze_req = 1'b1;
      while (items_sent - base < (ph + 1) * RANDOM_ITEMS / 4) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          build_junk();
        end else begin
          build_record(roll < 25);
        end
        drain_bytes();
      end
    end
    in_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (4) @(posedge clk);

    $display("Sent %0d bytes in %0d records (%0d clean) plus junk runs; %0d positions checked,",
             items_sent, records_built, clean_records, positions_seen);
    $display("with sender gaps, receiver stalls and one %0d-cycle output hold-off.",
             SQUEEZE_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[fen_position_parser_unit] OK");
    end else begin
      $display("[fen_position_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/fen_pp_pkg.sv
sv/fen_pp_place.sv
sv/fen_position_parser_unit.sv
tb/sv/fen_position_checker.sv
tb/sv/fen_position_parser_unit_tb.sv
